// File: hdl/scc_pkg.sv
package scc_pkg;

  typedef logic [2:0]  byte_pos_t;
  typedef logic [15:0] crc_t;

  localparam crc_t      CRC_INIT       = 16'hFFFF;
  localparam crc_t      CRC_POLY       = 16'hA001;
  localparam byte_pos_t POS_FIRST      = 3'd0;
  localparam byte_pos_t POS_HOLD_FIRST = 3'd2;
  localparam byte_pos_t POS_CRC_LO     = 3'd6;
  localparam byte_pos_t POS_LAST       = 3'd7;
  localparam logic [14:0] MAG_MASK     = 15'h7FFF;

  // reflected crc-16, one byte, lsb first
  function automatic crc_t crc_byte(input crc_t crc_in, input logic [7:0] b);
    crc_t c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/scc_in_if.sv
interface scc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// File: hdl/scc_out_if.sv
interface scc_out_if;
  logic               valid;
  logic               ready;
  logic               frame_ok;
  logic signed [15:0] temperature_tenths;
  logic        [15:0] humidity_tenths;

  modport source (output valid, output frame_ok, output temperature_tenths,
                  output humidity_tenths, input ready);
  modport sink   (input valid, input frame_ok, input temperature_tenths,
                  input humidity_tenths, output ready);
endinterface

// File: hdl/sensor_frame_crc_checker.sv
// channel   dir  payload                                          handshake
// in_if     in   data_byte[7:0], frame_start                      valid/ready
// out_if    out  frame_ok, temperature_tenths[15:0] (signed),     valid/ready
//                humidity_tenths[15:0]
//
// one byte per cycle unless stalled; crc update and frame check are done in
// the cycle a beat is taken, the result shows the cycle after the last byte.
// synchronous active-low reset: crc to 0xffff, byte position to 0, no result.
// a waiting result stalls the input only while the byte position sits on the
// last byte of a frame.
module sensor_frame_crc_checker
  import scc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  scc_in_if.sink    in_if,
  scc_out_if.source out_if
);

  crc_t               crc_r, crc_nxt;
  byte_pos_t          pos_r, pos_nxt;
  logic [31:0]        hold_r, hold_nxt;
  logic [7:0]         crc_lo_r, crc_lo_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               ok_r, ok_nxt;
  logic signed [15:0] temp_r, temp_nxt;
  logic        [15:0] hum_r, hum_nxt;

  logic               accept;
  byte_pos_t          pos_cur;
  crc_t               crc_cur;
  crc_t               crc_upd;
  logic [14:0]        mag;
  logic               frame_end;

  assign in_if.ready = !out_valid_r || out_if.ready || (pos_r != POS_LAST);
  assign accept      = in_if.valid && in_if.ready;

  assign pos_cur   = in_if.frame_start ? POS_FIRST : pos_r;
  assign crc_cur   = in_if.frame_start ? CRC_INIT : crc_r;
  assign crc_upd   = crc_byte(crc_cur, in_if.data_byte);
  assign mag       = hold_r[14:0] & MAG_MASK;
  assign frame_end = accept && (pos_cur == POS_LAST);

  always_comb begin
    crc_nxt    = crc_r;
    pos_nxt    = pos_r;
    hold_nxt   = hold_r;
    crc_lo_nxt = crc_lo_r;
    if (accept) begin
      if (pos_cur < POS_CRC_LO) begin
        crc_nxt = crc_upd;
      end
      if ((pos_cur >= POS_HOLD_FIRST) && (pos_cur < POS_CRC_LO)) begin
        hold_nxt = {hold_r[23:0], in_if.data_byte};
      end
      if (pos_cur == POS_CRC_LO) begin
        crc_lo_nxt = in_if.data_byte;
      end
      if (pos_cur == POS_LAST) begin
        pos_nxt = POS_FIRST;
        crc_nxt = CRC_INIT;
      end else begin
        pos_nxt = pos_cur + 3'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    ok_nxt        = ok_r;
    temp_nxt      = temp_r;
    hum_nxt       = hum_r;
    if (frame_end) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = ({in_if.data_byte, crc_lo_r} == crc_cur);
      if (ok_nxt) begin
        hum_nxt  = hold_r[31:16];
        temp_nxt = hold_r[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end else begin
        hum_nxt  = '0;
        temp_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      pos_r       <= POS_FIRST;
      hold_r      <= '0;
      crc_lo_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      pos_r       <= pos_nxt;
      hold_r      <= hold_nxt;
      crc_lo_r    <= crc_lo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r   <= ok_nxt;
    temp_r <= temp_nxt;
    hum_r  <= hum_nxt;
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.frame_ok           = ok_r;
  assign out_if.temperature_tenths = temp_r;
  assign out_if.humidity_tenths    = hum_r;

endmodule

// File: test/tb.sv
module tb;
  import scc_pkg::*;

  typedef logic [0:7][7:0] frame_t;

  typedef enum logic {FCS_GOOD, FCS_BAD} fcs_e;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] temp;
    logic        [15:0] hum;
  } frame_result_t;

  typedef struct {
    frame_t        bytes;
    int            nbytes;
    logic          start;
    fcs_e          fcs;
    logic          pinned;
    frame_result_t res;
  } frame_row_t;

  typedef struct {
    int unsigned   beat;
    frame_result_t res;
  } pinned_result_t;

  logic clk;
  logic rst_n;

  scc_in_if  in_ch ();
  scc_out_if out_ch ();

  sensor_frame_crc_checker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  crc_t      crc_run;
  byte_pos_t frame_pos;
  logic [31:0] held_payload;
  logic [7:0]  held_crc_lo;

  frame_result_t  pending_frames [$];
  pinned_result_t pinned_frames [$];

  int          mismatches;
  int unsigned beats_sent;
  int unsigned beats_taken;
  bit          quiet;
  bit          hold_off;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #(8 * 400000);
    $display("end of test: mismatches");
    $finish;
  end

  // bit-serial form of the reflected crc-16
  function automatic crc_t crc16_fold(input crc_t acc, input logic [7:0] b);
    crc_t c;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic absorb_byte(input logic [7:0] b, input logic start,
                                       output frame_result_t r);
    byte_pos_t   p;
    logic [15:0] rx;
    logic [15:0] raw;
    r = '0;
    if (start) begin
      frame_pos = POS_FIRST;
      crc_run = CRC_INIT;
    end
    p = frame_pos;
    if (p < POS_CRC_LO) begin
      crc_run = crc16_fold(crc_run, b);
    end
    if (p >= POS_HOLD_FIRST && p < POS_CRC_LO) begin
      held_payload = {held_payload[23:0], b};
    end
    if (p == POS_CRC_LO) begin
      held_crc_lo = b;
    end
    if (p == POS_LAST) begin
      rx = {b, held_crc_lo};
      raw = held_payload[15:0];
      r.ok = (rx == crc_run);
      if (r.ok) begin
        r.hum = held_payload[31:16];
        r.temp = raw[15] ? -$signed({1'b0, raw[14:0]}) : $signed({1'b0, raw[14:0]});
      end
      frame_pos = POS_FIRST;
      crc_run = CRC_INIT;
      return 1'b1;
    end
    frame_pos = p + 3'd1;
    return 1'b0;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : scoreboard
    frame_result_t  got;
    frame_result_t  want;
    pinned_result_t pin;
    int unsigned    idx;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.frame_ok, out_ch.temperature_tenths, out_ch.humidity_tenths};
        if (pending_frames.size() == 0) begin
          flag_mismatch("unexpected result, frame_ok", got.ok, 0);
        end else begin
          want = pending_frames.pop_front();
          if (got.ok !== want.ok) flag_mismatch("frame_ok", got.ok, want.ok);
          if (got.temp !== want.temp) flag_mismatch("temperature_tenths", got.temp, want.temp);
          if (got.hum !== want.hum) flag_mismatch("humidity_tenths", got.hum, want.hum);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        idx = beats_taken;
        beats_taken++;
        if (absorb_byte(in_ch.data_byte, in_ch.frame_start, want)) begin
          if (pinned_frames.size() > 0 && pinned_frames[0].beat == idx) begin
            pin = pinned_frames.pop_front();
            want = pin.res;
          end
          pending_frames.push_back(want);
        end
      end
    end
  end

  // result side
  initial begin : result_sink
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (hold_off) begin
        gap = 200;
        hold_off = 1'b0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic start);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.frame_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_t f, input int n, input logic start, input fcs_e fcs);
    crc_t   c;
    frame_t g;
    g = f;
    c = CRC_INIT;
    for (int k = 0; k < 6; k++) begin
      c = crc16_fold(c, g[k]);
    end
    if (fcs == FCS_BAD) begin
      c = c ^ crc_t'($urandom_range(1, 16'hFFFF));
    end
    g[6] = c[7:0];
    g[7] = c[15:8];
    for (int k = 0; k < n; k++) begin
      send_beat(g[k], start && k == 0);
    end
  endtask

  initial begin : stimulus
    frame_row_t     plan [5];
    pinned_result_t pin;
    frame_t         fb;
    int             pick;
    int             waited;

    mismatches = 0;
    beats_sent = 0;
    beats_taken = 0;
    quiet = 1'b0;
    hold_off = 1'b0;
    crc_run = CRC_INIT;
    frame_pos = POS_FIRST;
    held_payload = '0;
    held_crc_lo = '0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.frame_start = 1'b0;

    plan = '{
      // first frame after reset, no start flag; temperature at its top
      '{64'h0000_0000_7FFF_0000, 8, 1'b0, FCS_GOOD, 1'b1, '{1'b1, 16'sd32767, 16'd0}},
      // follows on without start flag; both fields at their extremes
      '{64'hFFFF_FFFF_FFFF_0000, 8, 1'b0, FCS_GOOD, 1'b1, '{1'b1, -16'sd32767, 16'd65535}},
      // cut short, then discarded by the next start
      '{64'h0103_0000_0000_0000, 2, 1'b1, FCS_GOOD, 1'b0, '{1'b0, 16'sd0, 16'd0}},
      // negative zero
      '{64'h0103_01F4_8000_0000, 8, 1'b1, FCS_GOOD, 1'b1, '{1'b1, 16'sd0, 16'd500}},
      // crc mismatch zeroes the fields
      '{64'h0103_0123_0456_0000, 8, 1'b1, FCS_BAD, 1'b1, '{1'b0, 16'sd0, 16'd0}}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].pinned) begin
        pin.beat = beats_sent + 7;
        pin.res = plan[i].res;
        pinned_frames.push_back(pin);
      end
      send_frame(plan[i].bytes, plan[i].nbytes, plan[i].start, plan[i].fcs);
    end

    // long receiver stall so the input side backs up
    hold_off = 1'b1;
    while (beats_sent < 1400) begin
      quiet = ((beats_sent / 250) % 3 == 2);
      pick = $urandom_range(0, 99);
      for (int k = 0; k < 8; k++) begin
        fb[k] = 8'($urandom_range(0, 255));
      end
      if (pick < 8) begin
        fb[4] = 8'h80;
        fb[5] = 8'h00;
      end
      if (pick < 70) begin
        send_frame(fb, 8, 1'($urandom_range(0, 1)), FCS_GOOD);
      end else if (pick < 82) begin
        send_frame(fb, 8, 1'($urandom_range(0, 1)), FCS_BAD);
      end else if (pick < 92) begin
        send_frame(fb, $urandom_range(1, 7), 1'b1, FCS_GOOD);
      end else begin
        repeat ($urandom_range(1, 12)) begin
          send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    waited = 0;
    while (pending_frames.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_frames.size() != 0) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      repeat (10) @(posedge clk);
      if (mismatches == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
      $finish;
    end
  end

endmodule

// File: sim.f
hdl/scc_pkg.sv
hdl/scc_in_if.sv
hdl/scc_out_if.sv
hdl/sensor_frame_crc_checker.sv
test/tb.sv
